// ----- sv/sample_message_ring_packetizer_defines.svh -----
// Assertion macros for the sample message ring packetizer.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef SAMPLE_MESSAGE_RING_PACKETIZER_DEFINES_SVH
`define SAMPLE_MESSAGE_RING_PACKETIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMRP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/smrp_pkg.sv -----
// Shared constants, widths and controller/datapath command types
// for the sample message ring packetizer. Depends on nothing.
`timescale 1ns / 1ps

package smrp_pkg;

  localparam int MSG_BYTES   = 64;
  localparam int READINGS    = 32;
  localparam int SLOTS       = 16;

  localparam int CNT_W       = 16;
  localparam int RI_W        = 5;
  localparam int SAMPLE_W    = 16;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 7;

  localparam int MEM_BYTES   = SLOTS * MSG_BYTES;
  localparam int BANK_DEPTH  = (MEM_BYTES + 1) / 2;
  localparam int ROW_W       = $clog2(BANK_DEPTH);
  localparam int ADDR_W      = ROW_W + 1;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int MSG_W       = $clog2(MSG_BYTES);

  localparam int MIN_WAITING = 2;
  localparam int JUMP_WRAP   = ((65536 % SLOTS) + MIN_WAITING) % SLOTS;

  localparam logic [BYTE_W-1:0] OVERRUN_MARK = 8'h5F;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_POLL   = 1'b1;

  typedef struct packed {
    logic store;  // write one sample into the slot being built
    logic jump;   // move the read counter past an overrun
    logic start;  // begin a message send
    logic ovr;    // message to send is an overrun message
    logic step;   // issue one byte read of the current send
  } smrp_cmd_t;

  typedef struct packed {
    logic few;    // fewer than two complete messages waiting
    logic over;   // writer more than SLOTS messages ahead
    logic done;   // current read is the final byte of the message
  } smrp_status_t;

endpackage

// ----- sv/smrp_ctrl.sv -----
// Controller of the sample message ring packetizer: accepts items,
// decides what a poll does and sequences a send. Depends on smrp_pkg.
`timescale 1ns / 1ps

module smrp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  kind,
  input  logic                  link_ok,
  input  smrp_pkg::smrp_status_t sts,
  output smrp_pkg::smrp_cmd_t    cmd,
  output logic                  busy
);

  typedef enum logic {ST_IDLE, ST_SEND} state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   accept;
  logic   poll_go;

  assign accept  = start && !busy_r;
  assign poll_go = accept && (kind == smrp_pkg::KIND_POLL) && !sts.few;

  always_comb begin
    cmd.store = accept && (kind == smrp_pkg::KIND_SAMPLE);
    cmd.jump  = poll_go && sts.over;
    cmd.start = poll_go && link_ok;
    cmd.ovr   = sts.over;
    cmd.step  = (state_r == ST_SEND);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (sts.done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt == ST_SEND);
    end
  end

  assign busy = busy_r;

endmodule

// ----- sv/smrp_datapath.sv -----
// Datapath of the sample message ring packetizer: message counters, the
// two byte banks of the slot ring and the byte stream out. Depends on smrp_pkg.
`timescale 1ns / 1ps
`include "sample_message_ring_packetizer_defines.svh"

module smrp_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  smrp_pkg::smrp_cmd_t              cmd,
  input  logic [smrp_pkg::SAMPLE_W-1:0]   sample,
  output smrp_pkg::smrp_status_t           sts,
  output logic                            out_valid,
  output logic [smrp_pkg::BYTE_W-1:0]     out_byte,
  output logic                            out_is_overrun,
  output logic                            out_last
);

  localparam int CW = smrp_pkg::CNT_W;
  localparam int SW = smrp_pkg::SLOT_W;
  localparam int AW = smrp_pkg::ADDR_W;
  localparam int RW = smrp_pkg::ROW_W;
  localparam int BW = smrp_pkg::BYTE_W;
  localparam int PW = smrp_pkg::POS_W;
  localparam int MW = smrp_pkg::MSG_W;

  // Byte banks: even byte addresses in bank 0, odd in bank 1.
  logic [BW-1:0] bank0 [smrp_pkg::BANK_DEPTH];
  logic [BW-1:0] bank1 [smrp_pkg::BANK_DEPTH];

  logic [CW-1:0] wr_cnt_r, rd_cnt_r;
  logic [SW-1:0] wr_slot_r, rd_slot_r;
  logic [smrp_pkg::RI_W-1:0] ri_r;

  logic [AW-1:0] send_base_r;
  logic          send_ovr_r;
  logic [MW-1:0] k_r;

  logic [BW-1:0] b0_q_r, b1_q_r;
  logic          sel_q_r, ovr_q_r, first_q_r, out_last_r, out_valid_r;

  logic [CW-1:0] waiting;
  logic [AW-1:0] wr_base, rd_base, wa_hi, wa_lo, ra;
  logic [PW-1:0] pos;
  logic          hi_en, lo_en, msg_end;
  logic          b0_en, b1_en;
  logic [RW-1:0] b0_row, b1_row;
  logic [BW-1:0] b0_data, b1_data;
  logic [SW:0]   jump_add, jump_sum;
  logic [SW-1:0] jump_slot;

  // Status toward the controller.
  assign waiting  = wr_cnt_r - rd_cnt_r;
  assign sts.few  = waiting < CW'(smrp_pkg::MIN_WAITING);
  assign sts.over = waiting > CW'(smrp_pkg::SLOTS);
  assign sts.done = (k_r == MW'(smrp_pkg::MSG_BYTES - 1));

  // Write side: two bytes of a reading go to opposite banks.
  assign wr_base = AW'(wr_slot_r) * AW'(smrp_pkg::MSG_BYTES);
  assign pos     = {1'b0, ri_r, 1'b0};
  assign hi_en   = pos < PW'(smrp_pkg::MSG_BYTES);
  assign lo_en   = (pos + PW'(1)) < PW'(smrp_pkg::MSG_BYTES);
  assign wa_hi   = wr_base + AW'(pos);
  assign wa_lo   = wa_hi + AW'(1);
  assign msg_end = (ri_r == smrp_pkg::RI_W'(smrp_pkg::READINGS - 1));

  always_comb begin
    if (!wa_hi[0]) begin
      b0_en   = hi_en;
      b0_row  = wa_hi[RW:1];
      b0_data = sample[15:8];
      b1_en   = lo_en;
      b1_row  = wa_lo[RW:1];
      b1_data = sample[7:0];
    end else begin
      b1_en   = hi_en;
      b1_row  = wa_hi[RW:1];
      b1_data = sample[15:8];
      b0_en   = lo_en;
      b0_row  = wa_lo[RW:1];
      b0_data = sample[7:0];
    end
  end

  // Overrun jump: slot of (write - SLOTS + 2), minding the 16-bit wrap.
  assign jump_add  = (wr_cnt_r < CW'(smrp_pkg::SLOTS - smrp_pkg::MIN_WAITING)) ?
                     (SW+1)'(smrp_pkg::JUMP_WRAP) : (SW+1)'(smrp_pkg::MIN_WAITING);
  assign jump_sum  = {1'b0, wr_slot_r} + jump_add;
  assign jump_slot = (jump_sum >= (SW+1)'(smrp_pkg::SLOTS)) ?
                     SW'(jump_sum - (SW+1)'(smrp_pkg::SLOTS)) : SW'(jump_sum);

  assign rd_base = AW'(rd_slot_r) * AW'(smrp_pkg::MSG_BYTES);
  assign ra      = send_base_r + AW'(k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_cnt_r    <= '0;
      rd_cnt_r    <= '0;
      wr_slot_r   <= '0;
      rd_slot_r   <= '0;
      ri_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (msg_end) begin
          ri_r     <= '0;
          wr_cnt_r <= wr_cnt_r + CW'(1);
          if (wr_cnt_r == {CW{1'b1}} || wr_slot_r == SW'(smrp_pkg::SLOTS - 1)) begin
            wr_slot_r <= '0;
          end else begin
            wr_slot_r <= wr_slot_r + SW'(1);
          end
        end else begin
          ri_r <= ri_r + smrp_pkg::RI_W'(1);
        end
      end
      if (cmd.jump) begin
        rd_cnt_r  <= wr_cnt_r - CW'(smrp_pkg::SLOTS) + CW'(smrp_pkg::MIN_WAITING);
        rd_slot_r <= jump_slot;
      end else if (cmd.start) begin
        rd_cnt_r <= rd_cnt_r + CW'(1);
        if (rd_cnt_r == {CW{1'b1}} || rd_slot_r == SW'(smrp_pkg::SLOTS - 1)) begin
          rd_slot_r <= '0;
        end else begin
          rd_slot_r <= rd_slot_r + SW'(1);
        end
      end
      if (cmd.start) begin
        k_r <= '0;
      end else if (cmd.step) begin
        k_r <= k_r + MW'(1);
      end
      out_valid_r <= cmd.step;
    end
  end

  // Payload of a send: base, kind, and per-byte flags.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      send_base_r <= rd_base;
      send_ovr_r  <= cmd.ovr;
    end
    if (cmd.step) begin
      sel_q_r    <= ra[0];
      ovr_q_r    <= send_ovr_r;
      first_q_r  <= (k_r == '0);
      out_last_r <= sts.done;
    end
  end

  // Memory banks: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (cmd.store && b0_en) bank0[b0_row] <= b0_data;
    if (cmd.step) b0_q_r <= bank0[ra[RW:1]];
  end

  always_ff @(posedge clk) begin
    if (cmd.store && b1_en) bank1[b1_row] <= b1_data;
    if (cmd.step) b1_q_r <= bank1[ra[RW:1]];
  end

  always_comb begin
    if (ovr_q_r) begin
      out_byte = first_q_r ? smrp_pkg::OVERRUN_MARK : '0;
    end else begin
      out_byte = sel_q_r ? b1_q_r : b0_q_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_overrun = ovr_q_r;
  assign out_last       = out_last_r;

  `SMRP_ASSERT_NOW(a_store_idle, cmd.store, !cmd.step, "sample stored during a send")
  `SMRP_ASSERT_NXT(a_jump_gap, cmd.jump, (wr_cnt_r - rd_cnt_r) == CW'(smrp_pkg::SLOTS - smrp_pkg::MIN_WAITING), "overrun jump left wrong gap")
  `SMRP_ASSERT_NXT(a_last_follows, cmd.step && sts.done, out_valid_r && out_last_r, "final byte not flagged")
  `SMRP_ASSERT_NOW(a_slot_range, 1'b1, (wr_slot_r <= SW'(smrp_pkg::SLOTS - 1)) && (rd_slot_r <= SW'(smrp_pkg::SLOTS - 1)), "slot index out of range")

endmodule

// ----- sv/sample_message_ring_packetizer.sv -----
// Top level of the sample message ring packetizer: joins the controller
// and the datapath. Depends on smrp_pkg, smrp_ctrl and smrp_datapath.
`timescale 1ns / 1ps

//  channel   | strobe / hold   | payload
//  ----------+-----------------+------------------------------------------
//  input     | start / busy    | in_kind, in_sample, in_link_ok
//  result    | out_valid       | out_byte, out_is_overrun, out_last
//
//  A sample item leaves busy low; the next item can follow in the next cycle.
//  A poll that sends holds busy while its bytes are read, one byte read a
//  cycle from the slot banks, and the next item waits until busy drops; the
//  first byte leaves once the sequencer has entered its send state and the
//  bank read registers have been loaded.
//  A poll that sends nothing leaves busy low.
//  Synchronous active-low reset clears the counters and the sequencer; the
//  slot memory is not cleared. The receiver cannot stall: each byte is
//  shown for exactly one cycle.
//
//  Samples are packed high byte first into the slot being built; a slot
//  holds READINGS readings, and bytes beyond MSG_BYTES are dropped. A poll
//  needs two complete messages waiting. When the writer runs more than SLOTS
//  messages ahead, move the read counter to writer - SLOTS + 2 and send one
//  overrun message (0x5F, then zeros) if the link is ready. A data send the
//  link refuses leaves the read counter alone.

module sample_message_ring_packetizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [smrp_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_link_ok,
  output logic                          out_valid,
  output logic [smrp_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_is_overrun,
  output logic                          out_last
);

  smrp_pkg::smrp_cmd_t    cmd;
  smrp_pkg::smrp_status_t sts;

  // Decide what each item does and sequence the byte reads of a send.
  smrp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .kind    (in_kind),
    .link_ok (in_link_ok),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Hold the counters and slot memory; stream the chosen message out.
  smrp_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sample         (in_sample),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_is_overrun (out_is_overrun),
    .out_last       (out_last)
  );

endmodule
